>>> rtl/rts_pkg.sv
// rts_pkg: shared types and constants for the rectilinear trilinear sampler
// used by rts_ctrl, rts_dp and rectilinear_trilinear_sampler_unit
package rts_pkg;

   localparam int POS_W   = 24;
   localparam int DIM_W   = 11;
   localparam int GRID_W  = 10;
   localparam int WGT_W   = 17;
   localparam int SLICE_W = 2 * DIM_W;
   localparam int ADDR_W  = 34;
   localparam int ENTRY_W = GRID_W + WGT_W;
   localparam int CSR_W   = 16;

   localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

   localparam logic [1:0] FUNC_VOXEL  = 2'd0;
   localparam logic [1:0] FUNC_TABLE  = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;
   localparam logic [1:0] FUNC_RSVD   = 2'd3;

   localparam logic [1:0] CSR_GRID_DIM_X = 2'd0;
   localparam logic [1:0] CSR_GRID_DIM_Y = 2'd1;
   localparam logic [1:0] CSR_ZERO_VALUE = 2'd2;

   typedef struct packed {
      logic [1:0]               func;
      logic [14:0]              voxel_addr;
      logic signed [15:0]       voxel_value;
      logic [1:0]               table_axis;
      logic [10:0]              table_index;
      logic [GRID_W-1:0]        table_grid_index;
      logic [WGT_W-1:0]         table_weight;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_value;
      logic               out_of_range;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TABLE,
      ST_BASE1,
      ST_BASE2,
      ST_READ,
      ST_MAC,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       load;
      logic       rd_en;
      logic [2:0] rd_idx;
      logic       mac_en;
      logic [3:0] mac_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic oor;
      logic out_free;
   } status_type;

endpackage

>>> rtl/rts_ctrl.sv
// rts_ctrl: sequencer for table lookup, voxel reads and multiply-accumulate steps
// depends on rts_pkg
module rts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_func,
   output logic                req_stall,
   input  rts_pkg::status_type status,
   output rts_pkg::cmd_type    cmd
);

   rts_pkg::state_type state_ff, state_in;
   logic [3:0]         cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rts_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      req_stall = 1'b1;
      case (state_ff)
         rts_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && req_func == rts_pkg::FUNC_SAMPLE) begin
               cmd.load = 1'b1;
               state_in = status.oor ? rts_pkg::ST_DONE : rts_pkg::ST_TABLE;
            end
         end
         rts_pkg::ST_TABLE: state_in = rts_pkg::ST_BASE1;
         rts_pkg::ST_BASE1: state_in = rts_pkg::ST_BASE2;
         rts_pkg::ST_BASE2: begin
            state_in = rts_pkg::ST_READ;
            cnt_in   = '0;
         end
         rts_pkg::ST_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = cnt_ff[2:0];
            cnt_in     = cnt_ff + 4'd1;
            if (cnt_ff[2:0] == 3'd7) begin
               state_in = rts_pkg::ST_MAC;
               cnt_in   = '0;
            end
         end
         rts_pkg::ST_MAC: begin
            cmd.mac_en   = 1'b1;
            cmd.mac_step = cnt_ff;
            cnt_in       = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) state_in = rts_pkg::ST_DRAIN;
         end
         rts_pkg::ST_DRAIN: state_in = rts_pkg::ST_DONE;
         rts_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = rts_pkg::ST_IDLE;
            end
         end
         default: state_in = rts_pkg::ST_IDLE;
      endcase
   end

   a_inrange_goes_table: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !status.oor) |=> state_ff == rts_pkg::ST_TABLE)
      else $error("in-range sample did not start table lookup");
   a_read_to_mac: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rts_pkg::ST_READ && cnt_ff[2:0] == 3'd7) |=> state_ff == rts_pkg::ST_MAC)
      else $error("voxel reads did not hand over to accumulate");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over a waiting transaction");
   a_no_mac_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rts_pkg::ST_IDLE) |-> !(cmd.mac_en || cmd.rd_en))
      else $error("datapath work issued while idle");

endmodule

>>> rtl/rts_dp.sv
// rts_dp: voxel store, axis tables, address generation and shared multiply-accumulate
// depends on rts_pkg; driven by rts_ctrl commands
module rts_dp #(
   parameter int VOXELS     = 32768,
   parameter int TABLE_SIZE = 1024,
   parameter int VALUE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  rts_pkg::req_type    req_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [rts_pkg::CSR_W-1:0] csr_wdata,
   input  rts_pkg::cmd_type    cmd,
   output rts_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rts_pkg::rsp_type    rsp_data
);

   localparam int VOX_AW     = $clog2(VOXELS);
   localparam int TAB_N      = TABLE_SIZE + 1;
   localparam int TAB_AW     = $clog2(TAB_N);
   localparam int STORE_BITS = (VALUE_BITS < 16) ? VALUE_BITS : 16;

   // configuration
   logic [rts_pkg::DIM_W-1:0]   dimx_ff, dimy_ff;
   logic signed [15:0]          zero_ff;
   logic [rts_pkg::SLICE_W-1:0] slice_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimx_ff <= 11'd32;
         dimy_ff <= 11'd32;
         zero_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rts_pkg::CSR_GRID_DIM_X: dimx_ff <= csr_wdata[rts_pkg::DIM_W-1:0];
            rts_pkg::CSR_GRID_DIM_Y: dimy_ff <= csr_wdata[rts_pkg::DIM_W-1:0];
            rts_pkg::CSR_ZERO_VALUE: zero_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      slice_ff <= {11'b0, dimx_ff} * {11'b0, dimy_ff};
   end

   // floors and range check
   logic signed [15:0] fl [3];
   logic [2:0]         oor_axis;
   logic [TAB_AW-1:0]  fl_ff [3];
   logic               oor_ff;

   assign fl[0] = req_data.pos_x[rts_pkg::POS_W-1:8];
   assign fl[1] = req_data.pos_y[rts_pkg::POS_W-1:8];
   assign fl[2] = req_data.pos_z[rts_pkg::POS_W-1:8];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         oor_axis[a] = fl[a][15] || ({16'b0, fl[a]} > 32'(TABLE_SIZE));
      end
   end

   assign status.oor = |oor_axis;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         oor_ff <= |oor_axis;
         for (int a = 0; a < 3; a++) fl_ff[a] <= TAB_AW'({16'b0, fl[a]});
      end
   end

   // axis tables
   logic [31:0]                 tab_idx32;
   logic                        tab_ok;
   logic [rts_pkg::WGT_W-1:0]   wsat;
   logic [rts_pkg::ENTRY_W-1:0] tab_rd_ff [3];

   assign tab_idx32 = {21'b0, req_data.table_index};
   assign tab_ok = cmd.accept && req_data.func == rts_pkg::FUNC_TABLE
                   && tab_idx32 <= 32'(TABLE_SIZE);
   assign wsat = (req_data.table_weight > rts_pkg::ONE_Q16) ? rts_pkg::ONE_Q16
                                                            : req_data.table_weight;

   for (genvar a = 0; a < 3; a++) begin : g_tab
      logic [rts_pkg::ENTRY_W-1:0] tab_mem [TAB_N];
      always_ff @(posedge clock) begin
         if (tab_ok && req_data.table_axis == 2'(a))
            tab_mem[tab_idx32[TAB_AW-1:0]] <= {req_data.table_grid_index, wsat};
         tab_rd_ff[a] <= tab_mem[fl_ff[a]];
      end
   end

   logic [rts_pkg::WGT_W-1:0]  wl [3];
   logic [rts_pkg::WGT_W-1:0]  wu [3];
   logic [rts_pkg::GRID_W-1:0] gidx [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         wl[a]   = tab_rd_ff[a][rts_pkg::WGT_W-1:0];
         wu[a]   = rts_pkg::ONE_Q16 - wl[a];
         gidx[a] = tab_rd_ff[a][rts_pkg::ENTRY_W-1:rts_pkg::WGT_W];
      end
   end

   // base address
   logic [20:0]                row_prod_ff;
   logic [31:0]                slc_prod_ff;
   logic [rts_pkg::ADDR_W-1:0] base_ff;

   always_ff @(posedge clock) begin
      row_prod_ff <= {11'b0, gidx[1]} * {10'b0, dimx_ff};
      slc_prod_ff <= {22'b0, gidx[2]} * {10'b0, slice_ff};
      base_ff     <= rts_pkg::ADDR_W'(gidx[0]) + rts_pkg::ADDR_W'(row_prod_ff)
                     + rts_pkg::ADDR_W'(slc_prod_ff);
   end

   // voxel store, single port
   logic [STORE_BITS-1:0]      vox_mem [VOXELS];
   logic [STORE_BITS-1:0]      vox_rd_ff;
   logic                       vox_we;
   logic [31:0]                vox_wa32;
   logic [rts_pkg::ADDR_W-1:0] rd_addr;
   logic                       rd_ok;
   logic                       rd_en_ff, rd_ok_ff;
   logic [2:0]                 rd_idx_ff;
   logic signed [33:0]         vox_ff [8];

   assign vox_wa32 = {17'b0, req_data.voxel_addr};
   assign vox_we = cmd.accept && req_data.func == rts_pkg::FUNC_VOXEL
                   && vox_wa32 < 32'(VOXELS);
   assign rd_addr = base_ff
                    + (cmd.rd_idx[2] ? rts_pkg::ADDR_W'(slice_ff) : '0)
                    + (cmd.rd_idx[1] ? rts_pkg::ADDR_W'(dimx_ff) : '0)
                    + rts_pkg::ADDR_W'(cmd.rd_idx[0]);
   assign rd_ok = rd_addr < rts_pkg::ADDR_W'(VOXELS);

   always_ff @(posedge clock) begin
      if (vox_we) vox_mem[vox_wa32[VOX_AW-1:0]] <= req_data.voxel_value[STORE_BITS-1:0];
      else if (cmd.rd_en) vox_rd_ff <= vox_mem[rd_addr[VOX_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) rd_en_ff <= 1'b0;
      else rd_en_ff <= cmd.rd_en;
      rd_ok_ff  <= rd_ok;
      rd_idx_ff <= cmd.rd_idx;
      if (rd_en_ff) vox_ff[rd_idx_ff] <= rd_ok_ff ? 34'($signed(vox_rd_ff)) : '0;
   end

   // shared multiply-accumulate: x pairs, then y pairs, then z in two halves
   logic signed [33:0] mac_a;
   logic [rts_pkg::WGT_W-1:0] mac_w;
   logic               mac_sh;
   logic signed [51:0] prod_in, prod_ff;
   logic               mac_en_ff, sh_ff;
   logic [3:0]         step_ff;
   logic signed [63:0] acc_ff, acc_nx, term;
   logic               first, last;
   logic signed [33:0] xs_ff [4];
   logic signed [49:0] ys_ff [2];
   logic [63:0]        mag;
   logic signed [15:0] res_in, res_ff;

   always_comb begin
      mac_sh = 1'b0;
      if (!cmd.mac_step[3]) begin
         mac_a = vox_ff[cmd.mac_step[2:0]];
         mac_w = cmd.mac_step[0] ? wu[0] : wl[0];
      end else if (!cmd.mac_step[2]) begin
         mac_a = xs_ff[cmd.mac_step[1:0]];
         mac_w = cmd.mac_step[0] ? wu[1] : wl[1];
      end else begin
         // upper half carries a 24-bit shift on accumulate
         mac_sh = cmd.mac_step[0];
         mac_a  = cmd.mac_step[0] ? 34'(ys_ff[cmd.mac_step[1]] >>> 24)
                                  : {10'b0, ys_ff[cmd.mac_step[1]][23:0]};
         mac_w  = cmd.mac_step[1] ? wu[2] : wl[2];
      end
   end

   assign prod_in = mac_a * $signed({1'b0, mac_w});

   always_ff @(posedge clock) begin
      if (reset) mac_en_ff <= 1'b0;
      else mac_en_ff <= cmd.mac_en;
      prod_ff <= prod_in;
      step_ff <= cmd.mac_step;
      sh_ff   <= mac_sh;
   end

   always_comb begin
      term   = sh_ff ? (64'(prod_ff) <<< 24) : 64'(prod_ff);
      first  = (step_ff[3:2] == 2'b11) ? (step_ff == 4'd12) : !step_ff[0];
      last   = (step_ff[3:2] == 2'b11) ? (step_ff == 4'd15) : step_ff[0];
      acc_nx = (first ? 64'sd0 : acc_ff) + term;
      mag    = acc_nx[63] ? (64'd0 - acc_nx) : acc_nx;
      res_in = acc_nx[63] ? (16'd0 - mag[63:48]) : mag[63:48];
   end

   always_ff @(posedge clock) begin
      if (mac_en_ff) begin
         acc_ff <= acc_nx;
         if (last) begin
            if (!step_ff[3]) xs_ff[step_ff[2:1]] <= acc_nx[33:0];
            else if (!step_ff[2]) ys_ff[step_ff[1]] <= acc_nx[49:0];
            else res_ff <= res_in;
         end
      end
   end

   // output register
   logic             rsp_valid_ff;
   rts_pkg::rsp_type rsp_data_ff;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      if (cmd.out_load) begin
         rsp_data_ff.sample_value <= oor_ff ? zero_ff : res_ff;
         rsp_data_ff.out_of_range <= oor_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/rectilinear_trilinear_sampler_unit.sv
// rectilinear_trilinear_sampler_unit: top level of the rectilinear trilinear sampler
// depends on rts_pkg, rts_ctrl and rts_dp
//
// Usage:
//  - req channel (req_valid/req_stall/req_data) carries voxel writes, axis table
//    writes and sample requests; rsp channel returns one transaction per sample.
//  - csr port writes grid_dim_x, grid_dim_y and zero_value; write only when idle.
//  - an in-range sample runs table lookup and base address, then 8 reads of the
//    single-port voxel memory, 16 steps of one shared 34x18 multiplier, then
//    result load.
//  - an out-of-range sample skips the lookup and returns zero_value.
//  - one sample is worked on at a time; req_stall is high while it runs.
//  - a finished result sits in the output register; while rsp_stall is high the
//    block keeps taking write transactions but holds the next sample result.
//  - reset (synchronous) clears control and restores register defaults; voxel
//    and table memories keep no reset value and must be loaded first.
module rectilinear_trilinear_sampler_unit #(
   parameter int VOXELS     = 32768,
   parameter int TABLE_SIZE = 1024,
   parameter int VALUE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  rts_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rts_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [rts_pkg::CSR_W-1:0] csr_wdata
);

   rts_pkg::cmd_type    cmd;
   rts_pkg::status_type status;

   rts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rts_dp #(
      .VOXELS     (VOXELS),
      .TABLE_SIZE (TABLE_SIZE),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> bench/tb_top.sv
// tb_top: self-checking bench for rectilinear_trilinear_sampler_unit
// depends on rts_pkg and the sampler rtl; carries its own sample predictor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_VOX   = 32768;
   localparam int N_TAB   = 1025;
   localparam int PER_PHASE = 190;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rts_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rts_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [rts_pkg::CSR_W-1:0] csr_wdata = '0;

   rectilinear_trilinear_sampler_unit uut (.*);

   always #5 clock = ~clock;

   // predictor copy of the block state
   logic signed [15:0] vox_mem [N_VOX];
   logic [rts_pkg::GRID_W-1:0] tab_grid [3][N_TAB];
   logic [rts_pkg::WGT_W-1:0]  tab_wgt [3][N_TAB];
   bit vox_set [N_VOX];
   bit tab_set [3][N_TAB];
   int unsigned dim_x = 32, dim_y = 32;
   logic [15:0] zero_val = '0;

   rts_pkg::rsp_type pending_samples[$];
   bit failed = 1'b0;
   bit quiet = 1'b0;   // no idling on either side
   int n_sent = 0;

   typedef struct {
      rts_pkg::req_type req;
      bit               typed;
      rts_pkg::rsp_type want;
   } stim_row;

   function automatic longint vox_read(longint addr);
      if (addr < N_VOX) return longint'(vox_mem[addr]);
      return 0;
   endfunction

   function automatic rts_pkg::rsp_type blend_sample(rts_pkg::req_type r);
      rts_pkg::rsp_type o;
      int fl[3];
      bit oor;
      longint row, slice, base, addr, acc;
      longint wl[3], wu[3], xs[2], ys[2];
      logic [63:0] mag, q;
      fl[0] = int'(r.pos_x) >>> 8;
      fl[1] = int'(r.pos_y) >>> 8;
      fl[2] = int'(r.pos_z) >>> 8;
      oor = 1'b0;
      for (int a = 0; a < 3; a++)
         if (fl[a] < 0 || fl[a] > N_TAB - 1) oor = 1'b1;
      if (oor) begin
         o.sample_value = zero_val;
         o.out_of_range = 1'b1;
         return o;
      end
      row = dim_x;
      slice = longint'(dim_x) * dim_y;
      base = longint'(tab_grid[0][fl[0]]) + longint'(tab_grid[1][fl[1]]) * row
           + longint'(tab_grid[2][fl[2]]) * slice;
      for (int a = 0; a < 3; a++) begin
         wl[a] = longint'(tab_wgt[a][fl[a]]);
         wu[a] = 65536 - wl[a];
      end
      for (int z = 0; z < 2; z++) begin
         for (int y = 0; y < 2; y++) begin
            addr = base + z * slice + y * row;
            xs[y] = vox_read(addr) * wl[0] + vox_read(addr + 1) * wu[0];
         end
         ys[z] = xs[0] * wl[1] + xs[1] * wu[1];
      end
      acc = ys[0] * wl[2] + ys[1] * wu[2];
      mag = (acc < 0) ? (64'd0 - acc) : acc;
      q = mag >> 48;
      o.sample_value = (acc < 0) ? 16'(64'd0 - q) : 16'(q);
      o.out_of_range = 1'b0;
      return o;
   endfunction

   // apply one accepted transaction to the predictor state
   function automatic void absorb(rts_pkg::req_type r, output bit has_rsp,
                                  output rts_pkg::rsp_type o);
      has_rsp = 1'b0;
      o = '0;
      case (r.func)
         rts_pkg::FUNC_VOXEL: begin
            vox_mem[r.voxel_addr] = r.voxel_value;
            vox_set[r.voxel_addr] = 1'b1;
         end
         rts_pkg::FUNC_TABLE: begin
            if (r.table_axis < 3 && r.table_index < N_TAB) begin
               tab_grid[r.table_axis][r.table_index] = r.table_grid_index;
               tab_wgt[r.table_axis][r.table_index] =
                  (r.table_weight > rts_pkg::ONE_Q16) ? rts_pkg::ONE_Q16 : r.table_weight;
               tab_set[r.table_axis][r.table_index] = 1'b1;
            end
         end
         rts_pkg::FUNC_SAMPLE: begin
            has_rsp = 1'b1;
            o = blend_sample(r);
         end
         default: ;
      endcase
   endfunction

   // grid index, mostly small so samples share neighbours
   function automatic int small_grid();
      if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 1023));
      return int'($urandom_range(0, 7));
   endfunction

   // next write that a sample needs so it reads only loaded entries
   function automatic bit fill_req(rts_pkg::req_type r, output rts_pkg::req_type w);
      int fl[3];
      longint row, slice, base, addr;
      w = '0;
      if (r.func != rts_pkg::FUNC_SAMPLE) return 1'b0;
      fl[0] = int'(r.pos_x) >>> 8;
      fl[1] = int'(r.pos_y) >>> 8;
      fl[2] = int'(r.pos_z) >>> 8;
      for (int a = 0; a < 3; a++)
         if (fl[a] < 0 || fl[a] > N_TAB - 1) return 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (!tab_set[a][fl[a]]) begin
            w = mk_table(a, fl[a], small_grid(), int'($urandom_range(0, 65536)));
            return 1'b1;
         end
      end
      row = dim_x;
      slice = longint'(dim_x) * dim_y;
      base = longint'(tab_grid[0][fl[0]]) + longint'(tab_grid[1][fl[1]]) * row
           + longint'(tab_grid[2][fl[2]]) * slice;
      for (int z = 0; z < 2; z++)
         for (int y = 0; y < 2; y++)
            for (int x = 0; x < 2; x++) begin
               addr = base + z * slice + y * row + x;
               if (addr < N_VOX && !vox_set[addr]) begin
                  w = mk_voxel(int'(addr), int'($urandom));
                  return 1'b1;
               end
            end
      return 1'b0;
   endfunction

   task automatic send(rts_pkg::req_type r, bit typed = 1'b0, rts_pkg::rsp_type want = '0);
      bit has_rsp;
      rts_pkg::rsp_type o;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      absorb(r, has_rsp, o);
      n_sent++;
      if (has_rsp) pending_samples.push_back(typed ? want : o);
      @(negedge clock);
   endtask

   // load whatever a sample reads, then send it
   task automatic send_item(rts_pkg::req_type r, bit typed = 1'b0,
                            rts_pkg::rsp_type want = '0);
      rts_pkg::req_type w;
      while (fill_req(r, w)) send(w);
      send(r, typed, want);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      wait (pending_samples.size() == 0);
      repeat (40) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [rts_pkg::CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         rts_pkg::CSR_GRID_DIM_X: dim_x = val[rts_pkg::DIM_W-1:0];
         rts_pkg::CSR_GRID_DIM_Y: dim_y = val[rts_pkg::DIM_W-1:0];
         rts_pkg::CSR_ZERO_VALUE: zero_val = val;
         default: ;
      endcase
   endtask

   // table coordinate, mostly in a low window with some at the top edge
   function automatic logic [23:0] rand_pos();
      if ($urandom_range(0, 7) == 0)
         return 24'($urandom_range(1020 * 256, N_TAB * 256 - 1));
      return 24'($urandom_range(0, 16 * 256 - 1));
   endfunction

   function automatic rts_pkg::req_type random_req();
      rts_pkg::req_type r;
      logic [159:0] raw;
      int pick;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(rts_pkg::req_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 15) r.func = rts_pkg::FUNC_VOXEL;
      else if (pick < 27) begin
         r.func = rts_pkg::FUNC_TABLE;
         if ($urandom_range(0, 9) != 0) begin
            r.table_axis = 2'($urandom_range(0, 2));
            r.table_index = ($urandom_range(0, 1) == 0) ? 11'($urandom_range(0, 15))
                                                        : 11'($urandom_range(0, N_TAB - 1));
         end
         if ($urandom_range(0, 3) != 0) r.table_grid_index = 10'(small_grid());
         if ($urandom_range(0, 4) != 0) r.table_weight = 17'($urandom_range(0, 65536));
      end else if (pick < 31) r.func = rts_pkg::FUNC_RSVD;
      else begin
         r.func = rts_pkg::FUNC_SAMPLE;
         if ($urandom_range(0, 6) != 0) begin
            r.pos_x = rand_pos();
            r.pos_y = rand_pos();
            r.pos_z = rand_pos();
         end
      end
      return r;
   endfunction

   function automatic rts_pkg::req_type mk_sample(int px, int py, int pz);
      rts_pkg::req_type r;
      r = '0;
      r.func = rts_pkg::FUNC_SAMPLE;
      r.pos_x = 24'(px);
      r.pos_y = 24'(py);
      r.pos_z = 24'(pz);
      return r;
   endfunction

   function automatic rts_pkg::req_type mk_table(int ax, int idx, int g, int w);
      rts_pkg::req_type r;
      r = '0;
      r.func = rts_pkg::FUNC_TABLE;
      r.table_axis = 2'(ax);
      r.table_index = 11'(idx);
      r.table_grid_index = 10'(g);
      r.table_weight = 17'(w);
      return r;
   endfunction

   function automatic rts_pkg::req_type mk_voxel(int addr, int val);
      rts_pkg::req_type r;
      r = '0;
      r.func = rts_pkg::FUNC_VOXEL;
      r.voxel_addr = 15'(addr);
      r.voxel_value = 16'(val);
      return r;
   endfunction

   // rsp stall bursts
   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 15) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rts_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            failed = 1'b1;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_data.sample_value !== want.sample_value) begin
               $display("%0t: sample_value expected %h actual %h", $time,
                        want.sample_value, rsp_data.sample_value);
               failed = 1'b1;
            end
            if (rsp_data.out_of_range !== want.out_of_range) begin
               $display("%0t: out_of_range expected %b actual %b", $time,
                        want.out_of_range, rsp_data.out_of_range);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      stim_row rows[$];
      stim_row sr;
      logic [rts_pkg::CSR_W-1:0] settings[5][3];
      rts_pkg::rsp_type oor0;
      int limit, mid;
      bit paused;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at reset settings, zero value is 0
      oor0.sample_value = 16'sd0;
      oor0.out_of_range = 1'b1;
      rows = '{
         '{mk_voxel(0, -32768), 0, '0},
         '{mk_voxel(32767, 32767), 0, '0},
         '{mk_voxel(1, 16'h1234), 0, '0},
         '{mk_table(3, 5, 7, 100), 0, '0},
         '{mk_table(0, 1025, 1, 1), 0, '0},
         '{mk_table(0, 2047, 1, 1), 0, '0},
         '{mk_table(0, 0, 0, 17'h1ffff), 0, '0},
         '{mk_table(1, 0, 0, 65536), 0, '0},
         '{mk_table(2, 0, 0, 0), 0, '0},
         '{mk_table(2, 1024, 1023, 32768), 0, '0},
         '{mk_table(0, 1024, 1023, 0), 0, '0},
         '{mk_sample(0, 0, 0), 0, '0},
         '{mk_sample(255, 255, 255), 0, '0},
         '{mk_sample(1024 * 256, 1024 * 256 + 255, 1024 * 256), 0, '0},
         '{mk_sample(-1, 0, 0), 1, oor0},
         '{mk_sample(0, 1025 * 256, 0), 1, oor0},
         '{mk_sample(0, 0, 8388607), 1, oor0},
         '{mk_sample(-8388608, -8388608, -8388608), 1, oor0},
         '{mk_sample(8388607, 8388607, 8388607), 1, oor0}
      };
      begin
         rts_pkg::req_type f3;
         f3 = '1;
         f3.func = rts_pkg::FUNC_RSVD;
         rows.push_back('{f3, 0, '0});
      end
      foreach (rows[i]) begin
         sr = rows[i];
         send_item(sr.req, sr.typed, sr.want);
      end
      limit = n_sent + PER_PHASE;
      while (n_sent < limit) send_item(random_req());
      settle();

      settings = '{'{2, 2, 16'h8000}, '{1024, 1024, 16'h7fff}, '{17, 5, 16'h1234},
                   '{2, 1024, 16'hffff}, '{0, 0, 0}};
      settings[4][0] = rts_pkg::CSR_W'($urandom_range(2, 1024));
      settings[4][1] = rts_pkg::CSR_W'($urandom_range(2, 1024));
      settings[4][2] = rts_pkg::CSR_W'($urandom);
      paused = 1'b0;
      for (int p = 0; p < 5; p++) begin
         csr_write(rts_pkg::CSR_GRID_DIM_X, settings[p][0]);
         csr_write(rts_pkg::CSR_GRID_DIM_Y, settings[p][1]);
         csr_write(rts_pkg::CSR_ZERO_VALUE, settings[p][2]);
         if (p == 4) quiet = 1'b1;
         mid = n_sent + PER_PHASE / 2;
         limit = n_sent + PER_PHASE;
         while (n_sent < limit) begin
            if (p == 1 && !paused && n_sent >= mid) begin
               settle();
               paused = 1'b1;
            end
            send_item(random_req());
         end
         settle();
      end

      if (!failed)
         $display("rectilinear_trilinear_sampler_unit test passed");
      else
         $display("rectilinear_trilinear_sampler_unit test failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("rectilinear_trilinear_sampler_unit test failed");
      $finish;
   end

endmodule
